### sv/kwm_pkg.sv
package kwm_pkg;

  localparam int MAX_RUNS_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 64;

  localparam int RUN_W  = 4;
  localparam int WORD_W = 64;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] RUN_COUNT_RST = 5'd16;

  // input tdata: run, word, zero pad
  localparam int IN_RUN_LSB  = 0;
  localparam int IN_WORD_LSB = IN_RUN_LSB + RUN_W;
  localparam int IN_TDATA_W  = 72;

  // output tdata: key_out, source_run, refill_run
  localparam int OUT_TDATA_W = WORD_W + 2 * RUN_W;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    CMD_WORD  = 1'b0,
    CMD_EMPTY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

### sv/k_way_sorted_run_merge.sv
// Merges up to run_count sorted runs of unsigned keys, holding one head key per run.
// Each request either delivers the next key of a run (in_tlast marks the last key of
// that run) or, with in_tuser set, declares a run empty. A request aimed at a run
// that is out of range, already holds a head or is finished gives a single result
// with out_tuser[1] set and all other fields zero. Once every unfinished run holds a
// head, the smallest head is sent out (a tie goes to the run that supplied the
// previous key, else the lowest index) together with the run to refill;
// out_tuser[0] marks the last key result of a request and out_tlast the final key of the
// whole merge, after which the block clears itself. Every decision is one pass of a
// single key comparator over the run heads, one head per cycle from the head memory;
// a further pass follows for each further key sent when a run ends, and a result
// may wait on out_tready. in_tready is low while a request is being worked on. The
// user writes run_count through cfg_we and cfg_wdata only while the block is idle;
// the block does not enforce this. 0 acts as 1 and values above MAX_RUNS as MAX_RUNS.
module k_way_sorted_run_merge #(
  parameter int MAX_RUNS  = kwm_pkg::MAX_RUNS_DEF,
  parameter int KEY_WIDTH = kwm_pkg::KEY_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kwm_pkg::IN_TDATA_W-1:0] in_tdata,   // run[3:0], word[67:4], zero pad
  input  logic                           in_tuser,   // cmd
  input  logic                           in_tlast,   // run_end

  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kwm_pkg::OUT_TDATA_W-1:0] out_tdata,  // key_out, source_run, refill_run
  output logic [kwm_pkg::OUT_TUSER_W-1:0] out_tuser,  // batch_last, bad_item
  output logic                            out_tlast,  // merge_done

  input  logic                           cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_RUNS);
  localparam int CNT_W = $clog2(MAX_RUNS + 1);

  kwm_pkg::state_t state_r, state_nxt;

  logic [kwm_pkg::CFG_W-1:0] run_count_r;
  logic [CNT_W-1:0]          rc;

  logic [MAX_RUNS-1:0] hv_r, hv_nxt;
  logic [MAX_RUNS-1:0] end_r, end_nxt;
  logic [MAX_RUNS-1:0] fin_r, fin_nxt;
  logic [IDX_W-1:0]    pref_r, pref_nxt;

  logic [KEY_WIDTH-1:0] head_mem [MAX_RUNS];
  logic [KEY_WIDTH-1:0] rd_r;
  logic                 mem_we;

  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                 proc_v_r, proc_v_nxt;
  logic [IDX_W-1:0]     proc_idx_r, proc_idx_nxt;
  logic                 all_done_r, all_done_nxt;
  logic                 ready_r, ready_nxt;
  logic                 any_r, any_nxt;
  logic                 found_r, found_nxt;
  logic [KEY_WIDTH-1:0] min_r, min_nxt;
  logic [IDX_W-1:0]     src_r, src_nxt;
  logic [1:0]           unf_cnt_r, unf_cnt_nxt;
  logic [IDX_W-1:0]     first_unf_r, first_unf_nxt;
  logic [IDX_W-1:0]     second_unf_r, second_unf_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [kwm_pkg::WORD_W-1:0] out_key_r, out_key_nxt;
  logic [kwm_pkg::RUN_W-1:0]  out_src_r, out_src_nxt;
  logic [kwm_pkg::RUN_W-1:0]  out_refill_r, out_refill_nxt;
  logic                       out_batch_r, out_batch_nxt;
  logic                       out_done_r, out_done_nxt;
  logic                       out_bad_r, out_bad_nxt;

  logic [kwm_pkg::RUN_W-1:0]  in_run;
  logic [kwm_pkg::WORD_W-1:0] in_word;
  logic [KEY_WIDTH-1:0]       in_key;
  logic [31:0]                run_ext;
  logic [IDX_W-1:0]           in_idx;
  logic                       in_bad;
  logic                       in_acc;
  logic                       out_free;
  logic [31:0]                src_ext;
  logic                       src_end;
  logic                       done_now;

  assign in_run  = in_tdata[kwm_pkg::IN_RUN_LSB +: kwm_pkg::RUN_W];
  assign in_word = in_tdata[kwm_pkg::IN_WORD_LSB +: kwm_pkg::WORD_W];
  assign in_key  = in_word[KEY_WIDTH-1:0];
  assign run_ext = 32'(in_run);
  assign in_idx  = run_ext[IDX_W-1:0];
  assign src_ext = 32'(src_r);

  always_comb begin
    if (run_count_r == '0) begin
      rc = CNT_W'(1);
    end else if (32'(run_count_r) > 32'(MAX_RUNS)) begin
      rc = CNT_W'(MAX_RUNS);
    end else begin
      rc = CNT_W'(run_count_r);
    end
  end

  assign in_bad   = (run_ext >= 32'(rc)) || hv_r[in_idx] || fin_r[in_idx];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == kwm_pkg::ST_IDLE) && out_free;
  assign in_acc   = in_tvalid && in_tready;
  assign src_end  = end_r[src_r];
  assign done_now = src_end && (unf_cnt_r == 2'd1);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_refill_r, out_src_r, out_key_r};
  assign out_tuser  = {out_bad_r, out_batch_r};
  assign out_tlast  = out_done_r;

  always_comb begin
    state_nxt      = state_r;
    hv_nxt         = hv_r;
    end_nxt        = end_r;
    fin_nxt        = fin_r;
    pref_nxt       = pref_r;
    mem_we         = 1'b0;
    scan_cnt_nxt   = scan_cnt_r;
    proc_v_nxt     = proc_v_r;
    proc_idx_nxt   = proc_idx_r;
    all_done_nxt   = all_done_r;
    ready_nxt      = ready_r;
    any_nxt        = any_r;
    found_nxt      = found_r;
    min_nxt        = min_r;
    src_nxt        = src_r;
    unf_cnt_nxt    = unf_cnt_r;
    first_unf_nxt  = first_unf_r;
    second_unf_nxt = second_unf_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_key_nxt    = out_key_r;
    out_src_nxt    = out_src_r;
    out_refill_nxt = out_refill_r;
    out_batch_nxt  = out_batch_r;
    out_done_nxt   = out_done_r;
    out_bad_nxt    = out_bad_r;

    unique case (state_r)
      kwm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_bad) begin
            out_valid_nxt  = 1'b1;
            out_key_nxt    = '0;
            out_src_nxt    = '0;
            out_refill_nxt = '0;
            out_batch_nxt  = 1'b0;
            out_done_nxt   = 1'b0;
            out_bad_nxt    = 1'b1;
          end else begin
            if (in_tuser == kwm_pkg::CMD_WORD) begin
              hv_nxt[in_idx]  = 1'b1;
              end_nxt[in_idx] = in_tlast;
              mem_we          = 1'b1;
            end else begin
              fin_nxt[in_idx] = 1'b1;
            end
            state_nxt    = kwm_pkg::ST_SCAN;
            scan_cnt_nxt = '0;
            proc_v_nxt   = 1'b0;
            all_done_nxt = 1'b1;
            ready_nxt    = 1'b1;
            any_nxt      = 1'b0;
            found_nxt    = 1'b0;
            unf_cnt_nxt  = '0;
          end
        end
      end

      kwm_pkg::ST_SCAN: begin
        // one head per cycle through the comparator
        if (proc_v_r) begin
          if (!fin_r[proc_idx_r]) begin
            all_done_nxt = 1'b0;
            if (hv_r[proc_idx_r]) begin
              any_nxt = 1'b1;
            end else begin
              ready_nxt = 1'b0;
            end
            if (unf_cnt_r == 2'd0) begin
              first_unf_nxt = proc_idx_r;
            end else if (unf_cnt_r == 2'd1) begin
              second_unf_nxt = proc_idx_r;
            end
            if (unf_cnt_r != 2'd2) begin
              unf_cnt_nxt = unf_cnt_r + 2'd1;
            end
          end
          if (hv_r[proc_idx_r] && (!found_r || rd_r < min_r ||
              (proc_idx_r == pref_r && rd_r == min_r))) begin
            min_nxt   = rd_r;
            src_nxt   = proc_idx_r;
            found_nxt = 1'b1;
          end
        end
        if (scan_cnt_r < rc) begin
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end else begin
          proc_v_nxt = 1'b0;
          if (!proc_v_r) begin
            state_nxt = kwm_pkg::ST_DECIDE;
          end
        end
      end

      kwm_pkg::ST_DECIDE: begin
        if (all_done_r) begin
          hv_nxt    = '0;
          end_nxt   = '0;
          fin_nxt   = '0;
          pref_nxt  = '0;
          state_nxt = kwm_pkg::ST_IDLE;
        end else if (!ready_r || !any_r) begin
          state_nxt = kwm_pkg::ST_IDLE;
        end else if (out_free) begin
          hv_nxt[src_r]  = 1'b0;
          end_nxt[src_r] = 1'b0;
          if (src_end) begin
            fin_nxt[src_r] = 1'b1;
            pref_nxt = (first_unf_r == src_r) ? second_unf_r : first_unf_r;
          end else begin
            pref_nxt = src_r;
          end
          out_valid_nxt  = 1'b1;
          out_key_nxt    = kwm_pkg::WORD_W'(min_r);
          out_src_nxt    = src_ext[kwm_pkg::RUN_W-1:0];
          out_refill_nxt = src_end ? '0 : src_ext[kwm_pkg::RUN_W-1:0];
          out_batch_nxt  = !src_end || done_now;
          out_done_nxt   = done_now;
          out_bad_nxt    = 1'b0;
          if (done_now) begin
            hv_nxt   = '0;
            end_nxt  = '0;
            fin_nxt  = '0;
            pref_nxt = '0;
          end
          if (!src_end || done_now) begin
            state_nxt = kwm_pkg::ST_IDLE;
          end else begin
            // a run ended, every other unfinished run still has a head: go again
            state_nxt    = kwm_pkg::ST_SCAN;
            scan_cnt_nxt = '0;
            proc_v_nxt   = 1'b0;
            all_done_nxt = 1'b1;
            ready_nxt    = 1'b1;
            any_nxt      = 1'b0;
            found_nxt    = 1'b0;
            unf_cnt_nxt  = '0;
          end
        end
      end

      default: begin
        state_nxt = kwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kwm_pkg::ST_IDLE;
      run_count_r <= kwm_pkg::RUN_COUNT_RST;
      hv_r        <= '0;
      end_r       <= '0;
      fin_r       <= '0;
      pref_r      <= '0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        run_count_r <= cfg_wdata;
      end
      hv_r        <= hv_nxt;
      end_r       <= end_nxt;
      fin_r       <= fin_nxt;
      pref_r      <= pref_nxt;
      proc_v_r    <= proc_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt_r   <= scan_cnt_nxt;
    proc_idx_r   <= proc_idx_nxt;
    all_done_r   <= all_done_nxt;
    ready_r      <= ready_nxt;
    any_r        <= any_nxt;
    found_r      <= found_nxt;
    min_r        <= min_nxt;
    src_r        <= src_nxt;
    unf_cnt_r    <= unf_cnt_nxt;
    first_unf_r  <= first_unf_nxt;
    second_unf_r <= second_unf_nxt;
    out_key_r    <= out_key_nxt;
    out_src_r    <= out_src_nxt;
    out_refill_r <= out_refill_nxt;
    out_batch_r  <= out_batch_nxt;
    out_done_r   <= out_done_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  // head memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      head_mem[in_idx] <= in_key;
    end
    rd_r <= head_mem[scan_cnt_r[IDX_W-1:0]];
  end

endmodule

### sv/kwm_checker.sv
module kwm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [kwm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [kwm_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                            out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // error result carries nothing else
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tlast && !out_tuser[0])
    else $error("error result with nonzero fields");

  // final key ends its request and asks for no refill
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tuser[0] && out_tdata[kwm_pkg::OUT_TDATA_W-1 -: kwm_pkg::RUN_W] == '0)
    else $error("merge end without batch end or with refill");

  // new requests only when the output register can take a result
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("ready while output blocked");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind k_way_sorted_run_merge kwm_checker u_kwm_checker (.*);
